// ----- rtl/scfa_pkg.sv -----
// ----------------------------------------------------------------------------
// scfa_pkg
// shared types and constants of the size class free list allocator
// ----------------------------------------------------------------------------
package scfa_pkg;

  localparam int NUM_CLASSES     = 24;
  localparam int CLS_W           = 5;
  localparam int SIZE_W          = 16;
  localparam int ADDR_W          = 48;
  localparam int ROUND_W         = 12;
  localparam int CNT_W           = 8;
  localparam int MAX_CACHED      = 2048;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int ADDR_BITS_DEF   = 48;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_SERVED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_STORED    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  result_address;
    logic [CLS_W-1:0]   size_class;
    logic [ROUND_W-1:0] rounded_bytes;
  } out_item_t;

  typedef struct packed {
    logic               too_large;
    logic [CLS_W-1:0]   cls;
    logic [ROUND_W-1:0] rounded;
  } class_info_t;

endpackage

// ----- rtl/size_class_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit
// a push or miss goes through the access state to the registered result; a pop also
// goes through the read state, since the address memory has a registered read port
// one request at a time: the input stalls until the result of the last one is loaded
// reset: synchronous active low, all class counts cleared at once
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_unit
  import scfa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_payload,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload
);

  localparam int STORE_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ACCESS = 3'b010,
    S_READ   = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               kind_r;
  logic [STORE_W-1:0] addr_r;
  class_info_t        info_r;
  class_info_t        cls_info;
  logic [CNT_W-1:0]   count_r [NUM_CLASSES];
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               accept;
  logic               out_ok;
  logic               load;
  logic [CNT_W-1:0]   cnt_cur;
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_val;
  logic [CNT_W-1:0]   idx;
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [MEM_AW-1:0]  mem_addr;
  logic [STORE_W-1:0] mem_rd_data;

  scfa_classify u_classify (
    .size_bytes (in_payload.size_bytes),
    .info       (cls_info)
  );

  scfa_store #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW),
    .DW    (STORE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_addr),
    .wr_data (addr_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_addr),
    .rd_data (mem_rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_ok   = !out_valid_r || !out_stall;
  assign cnt_cur  = count_r[info_r.cls];
  assign mem_addr = MEM_AW'(info_r.cls * STACK_DEPTH) + MEM_AW'(idx);

  always_comb begin
    state_nxt    = state_r;
    cnt_we       = 1'b0;
    cnt_val      = cnt_cur;
    idx          = cnt_cur;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    load         = 1'b0;
    out_item_nxt = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (!info_r.too_large && kind_r == KIND_ALLOC && cnt_cur != '0) begin
          // pop: read top entry, result is delivered after the read
          idx       = cnt_cur - CNT_W'(1);
          mem_rd_en = 1'b1;
          cnt_we    = 1'b1;
          cnt_val   = cnt_cur - CNT_W'(1);
          state_nxt = S_READ;
        end else if (out_ok) begin
          load                        = 1'b1;
          state_nxt                   = S_IDLE;
          out_item_nxt.result_address = '0;
          out_item_nxt.size_class     = info_r.cls;
          out_item_nxt.rounded_bytes  = info_r.rounded;
          if (info_r.too_large) begin
            out_item_nxt.status = ST_TOO_LARGE;
          end else if (kind_r == KIND_ALLOC) begin
            out_item_nxt.status = ST_EMPTY;
          end else if (cnt_cur >= DEPTH_CNT) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            out_item_nxt.status = ST_STORED;
            mem_wr_en           = 1'b1;
            cnt_we              = 1'b1;
            cnt_val             = cnt_cur + CNT_W'(1);
          end
        end
      end
      S_READ: begin
        if (out_ok) begin
          load                        = 1'b1;
          state_nxt                   = S_IDLE;
          out_item_nxt.status         = ST_SERVED;
          out_item_nxt.result_address = ADDR_W'(mem_rd_data);
          out_item_nxt.size_class     = info_r.cls;
          out_item_nxt.rounded_bytes  = info_r.rounded;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        count_r[i] <= '0;
      end
    end else if (cnt_we) begin
      count_r[info_r.cls] <= cnt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_payload.kind;
      addr_r <= in_payload.block_address[STORE_W-1:0];
      info_r <= cls_info;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACCESS |-> cnt_cur <= DEPTH_CNT)
    else $error("class count beyond stack depth");

  a_read_then_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |=> state_r == S_READ)
    else $error("store read not followed by read state");

  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_ACCESS || $past(state_r) == S_READ)
    else $error("result loaded outside access or read");
`endif

endmodule

// ----- rtl/scfa_classify.sv -----
// ----------------------------------------------------------------------------
// scfa_classify
// maps a byte size to its size class and rounded class size, or flags it too large
// ----------------------------------------------------------------------------
module scfa_classify
  import scfa_pkg::*;
(
  input  logic [SIZE_W-1:0] size_bytes,
  output class_info_t       info
);

  logic        too_large;
  logic [12:0] n;
  logic [2:0]  tier;
  logic [12:0] r;
  logic [3:0]  q;
  logic [CLS_W-1:0] cls;

  assign too_large = size_bytes > SIZE_W'(MAX_CACHED);
  assign n         = size_bytes[12:0];

  always_comb begin
    if (n <= 13'd128) begin
      tier = 3'd0;
    end else if (n <= 13'd256) begin
      tier = 3'd1;
    end else if (n <= 13'd512) begin
      tier = 3'd2;
    end else if (n <= 13'd1024) begin
      tier = 3'd3;
    end else begin
      tier = 3'd4;
    end
  end

  always_comb begin
    case (tier)
      3'd0: begin
        r = (n + 13'd15) & ~13'd15;
        q = r[7:4];
      end
      3'd1: begin
        r = (n + 13'd31) & ~13'd31;
        q = r[8:5];
      end
      3'd2: begin
        r = (n + 13'd63) & ~13'd63;
        q = r[9:6];
      end
      3'd3: begin
        r = (n + 13'd127) & ~13'd127;
        q = r[10:7];
      end
      default: begin
        r = (n + 13'd255) & ~13'd255;
        q = r[11:8];
      end
    endcase
    // zero size goes to the smallest class
    if (r == 13'd0) begin
      r = 13'd16;
      q = 4'd1;
    end
  end

  assign cls = CLS_W'({tier, 2'b00}) + CLS_W'(q) - CLS_W'(1);

  assign info.too_large = too_large;
  assign info.cls       = too_large ? '0 : cls;
  assign info.rounded   = too_large ? '0 : r[ROUND_W-1:0];

endmodule

// ----- rtl/scfa_store.sv -----
// ----------------------------------------------------------------------------
// scfa_store
// free block address memory, one write and one registered read port
// ----------------------------------------------------------------------------
module scfa_store
  import scfa_pkg::*;
#(
  parameter int DEPTH = NUM_CLASSES * STACK_DEPTH_DEF,
  parameter int AW    = $clog2(NUM_CLASSES * STACK_DEPTH_DEF),
  parameter int DW    = ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
